/* hdl/iprc_pkg.sv */
// ----------------------------------------------------------------------------
// IPv4 frame receive classifier package
// Request and result types, verdict and dispatch codes, register indexes.
// ----------------------------------------------------------------------------
package iprc_pkg;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } in_req_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [1:0]  dispatch;
        logic [7:0]  protocol_number;
        logic        is_broadcast;
        logic [5:0]  header_bytes;
        logic [15:0] payload_bytes;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic        arp_for_us;
        logic        arp_is_req;
        logic [31:0] arp_sender_address;
    } out_res_t;

    // frame summary passed from the parser to the judge
    typedef struct packed {
        logic [15:0] length;
        logic [15:0] ether_type;
        logic [16:0] header_sum;
        logic [7:0]  version_ihl;
        logic [15:0] ip_len;
        logic [15:0] fragment_word;
        logic [7:0]  protocol_byte;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] arp_hw;
        logic [15:0] arp_proto;
        logic [15:0] arp_op;
    } frame_sum_t;

    typedef enum logic [2:0] {
        VERDICT_IGNORED  = 3'd0,
        VERDICT_ARP_OK   = 3'd1,
        VERDICT_ARP_BAD  = 3'd2,
        VERDICT_IP_BAD   = 3'd3,
        VERDICT_IP_FRAG  = 3'd4,
        VERDICT_NOT_OURS = 3'd5,
        VERDICT_DELIVER  = 3'd6
    } verdict_t;

    localparam logic [1:0] DISPATCH_ICMP  = 2'd0;
    localparam logic [1:0] DISPATCH_UDP   = 2'd1;
    localparam logic [1:0] DISPATCH_TCP   = 2'd2;
    localparam logic [1:0] DISPATCH_UNRCH = 2'd3;

    localparam logic [1:0] REG_LOCAL_ADDRESS = 2'd0;
    localparam logic [1:0] REG_SUBNET_MASK   = 2'd1;
    localparam logic [1:0] REG_LOOPBACK_MODE = 2'd2;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
    localparam logic [15:0] FRAG_MASK      = 16'h3fff;

endpackage

/* hdl/iprc_parser.sv */
// ----------------------------------------------------------------------------
// IPv4 frame receive classifier byte parser
// Places each byte, captures header fields, folds the IPv4 header checksum,
// and pushes a frame summary on the last byte.
// ----------------------------------------------------------------------------
module iprc_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  iprc_pkg::in_req_t    s_data,
    output logic                 sum_valid,
    input  logic                 sum_ready,
    output iprc_pkg::frame_sum_t sum_data
);
    import iprc_pkg::*;

    frame_sum_t f_reg, f_next;
    logic       busy_reg, busy_next;
    logic [7:0] held_reg, held_next;
    frame_sum_t out_reg, out_next;

    logic        take;
    logic [15:0] o;
    logic [7:0]  v;
    logic [5:0]  hl;
    logic [16:0] s;

    assign s_ready   = !busy_reg || sum_ready;
    assign take      = s_valid && s_ready;
    assign sum_valid = busy_reg;
    assign sum_data  = out_reg;

    always_comb begin
        f_next    = f_reg;
        held_next = held_reg;
        busy_next = busy_reg && !sum_ready;
        out_next  = out_reg;
        v  = s_data.frame_byte;
        o  = f_reg.length - 16'd14;
        hl = {f_reg.version_ihl[3:0], 2'b00};
        s  = 17'd0;
        if (take) begin
            if (f_reg.length == 16'd12) begin
                f_next.ether_type = {v, 8'h00};
            end else if (f_reg.length == 16'd13) begin
                f_next.ether_type = {f_reg.ether_type[15:8], v};
            end else if (f_reg.length >= 16'd14 && f_reg.length != 16'hffff) begin
                if (f_reg.ether_type == ETHERTYPE_IPV4) begin
                    if (o == 16'd0) f_next.version_ihl = v;
                    else if (o == 16'd2) f_next.ip_len = {v, 8'h00};
                    else if (o == 16'd3) f_next.ip_len[7:0] = v;
                    else if (o == 16'd6) f_next.fragment_word = {v, 8'h00};
                    else if (o == 16'd7) f_next.fragment_word[7:0] = v;
                    else if (o == 16'd9) f_next.protocol_byte = v;
                    else if (o >= 16'd12 && o <= 16'd15) f_next.src = {f_reg.src[23:0], v};
                    else if (o >= 16'd16 && o <= 16'd19) f_next.dst = {f_reg.dst[23:0], v};
                    if (o < 16'd60) begin
                        if (!o[0]) begin
                            held_next = v;
                        end else if (o < {10'd0, hl}) begin
                            s = f_reg.header_sum + {1'b0, held_reg, v};
                            if (s[16]) s = {1'b0, s[15:0]} + 17'd1;
                            f_next.header_sum = s;
                        end
                    end
                end else if (f_reg.ether_type == ETHERTYPE_ARP) begin
                    if (o == 16'd0) f_next.arp_hw = {v, 8'h00};
                    else if (o == 16'd1) f_next.arp_hw[7:0] = v;
                    else if (o == 16'd2) f_next.arp_proto = {v, 8'h00};
                    else if (o == 16'd3) f_next.arp_proto[7:0] = v;
                    else if (o == 16'd6) f_next.arp_op = {v, 8'h00};
                    else if (o == 16'd7) f_next.arp_op[7:0] = v;
                    else if (o >= 16'd14 && o <= 16'd17) f_next.src = {f_reg.src[23:0], v};
                    else if (o >= 16'd24 && o <= 16'd27) f_next.dst = {f_reg.dst[23:0], v};
                end
            end
            if (f_reg.length != 16'hffff) f_next.length = f_reg.length + 16'd1;
            if (s_data.last_byte) begin
                out_next  = f_next;
                busy_next = 1'b1;
                f_next    = '0;
                held_next = 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_reg    <= '0;
            held_reg <= 8'd0;
            busy_reg <= 1'b0;
        end else begin
            f_reg    <= f_next;
            held_reg <= held_next;
            busy_reg <= busy_next;
        end
        out_reg <= out_next;
    end
endmodule

/* hdl/iprc_judge.sv */
// ----------------------------------------------------------------------------
// IPv4 frame receive classifier judge
// Turns a frame summary into one verdict and holds it in the result register.
// ----------------------------------------------------------------------------
module iprc_judge (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [31:0]          local_address,
    input  logic [31:0]          subnet_mask,
    input  logic                 loopback_mode,
    input  logic                 sum_valid,
    output logic                 sum_ready,
    input  iprc_pkg::frame_sum_t sum_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output iprc_pkg::out_res_t   m_data
);
    import iprc_pkg::*;

    logic     valid_reg, valid_next;
    out_res_t res_reg, res_next;
    out_res_t r;
    logic [15:0] body;
    logic [5:0]  hl;
    logic        bcast, ours;

    assign sum_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_data    = res_reg;

    always_comb begin
        r     = '0;
        body  = sum_data.length - 16'd14;
        hl    = {sum_data.version_ihl[3:0], 2'b00};
        bcast = sum_data.dst == 32'hffffffff ||
                (subnet_mask != 32'd0 && (sum_data.dst | subnet_mask) == 32'hffffffff);
        ours  = (local_address != 32'd0 && sum_data.dst == local_address) || bcast ||
                loopback_mode || (local_address == 32'd0 && sum_data.protocol_byte == 8'd17);
        if (sum_data.length < 16'd14) begin
            r.verdict = VERDICT_IGNORED;
        end else if (sum_data.ether_type == ETHERTYPE_ARP) begin
            if (body < 16'd28 || sum_data.arp_hw != 16'd1 ||
                sum_data.arp_proto != ETHERTYPE_IPV4) begin
                r.verdict = VERDICT_ARP_BAD;
            end else begin
                r.verdict            = VERDICT_ARP_OK;
                r.arp_for_us         = local_address != 32'd0 && sum_data.dst == local_address;
                r.arp_is_req         = sum_data.arp_op == 16'd1;
                r.arp_sender_address = sum_data.src;
            end
        end else if (sum_data.ether_type == ETHERTYPE_IPV4) begin
            if (body < 16'd20 || sum_data.version_ihl[7:4] != 4'd4 || hl < 6'd20 ||
                sum_data.ip_len < {10'd0, hl} || sum_data.ip_len > body ||
                sum_data.header_sum != 17'h0ffff) begin
                r.verdict = VERDICT_IP_BAD;
            end else begin
                r.protocol_number     = sum_data.protocol_byte;
                r.is_broadcast        = bcast;
                r.header_bytes        = hl;
                r.payload_bytes       = sum_data.ip_len - {10'd0, hl};
                r.source_address      = sum_data.src;
                r.destination_address = sum_data.dst;
                if ((sum_data.fragment_word & FRAG_MASK) != 16'd0) begin
                    r.verdict = VERDICT_IP_FRAG;
                end else if (!ours) begin
                    r.verdict = VERDICT_NOT_OURS;
                end else begin
                    r.verdict = VERDICT_DELIVER;
                    unique case (sum_data.protocol_byte)
                        8'd1:    r.dispatch = DISPATCH_ICMP;
                        8'd17:   r.dispatch = DISPATCH_UDP;
                        8'd6:    r.dispatch = DISPATCH_TCP;
                        default: r.dispatch = DISPATCH_UNRCH;
                    endcase
                end
            end
        end
        valid_next = valid_reg && !m_ready;
        res_next   = res_reg;
        if (sum_valid && sum_ready) begin
            valid_next = 1'b1;
            res_next   = r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end
endmodule

/* hdl/ipv4_frame_receive_classifier.sv */
// ----------------------------------------------------------------------------
// IPv4 frame receive classifier
// Last byte: summary goes to parser out_reg, then verdict to judge res_reg.
// Throughput: one byte per cycle unless the parser's summary is not taken.
// Parser holds one frame summary, judge one result; each stalls when full.
// Reset: synchronous active-low aresetn clears frame state, valid flags and config.
// ----------------------------------------------------------------------------
module ipv4_frame_receive_classifier (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  iprc_pkg::in_req_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output iprc_pkg::out_res_t m_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import iprc_pkg::*;

    logic [31:0] local_reg, mask_reg;
    logic        loop_reg;
    logic        sum_valid, sum_ready;
    frame_sum_t  sum_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_reg <= 32'd0;
            mask_reg  <= 32'd0;
            loop_reg  <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_index == REG_LOCAL_ADDRESS) local_reg <= cfg_data;
            if (cfg_index == REG_SUBNET_MASK)   mask_reg  <= cfg_data;
            if (cfg_index == REG_LOOPBACK_MODE) loop_reg  <= cfg_data[0];
        end
    end

    iprc_parser u_parser (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .sum_valid(sum_valid), .sum_ready(sum_ready), .sum_data(sum_data)
    );

    iprc_judge u_judge (
        .aclk(aclk), .aresetn(aresetn),
        .local_address(local_reg), .subnet_mask(mask_reg), .loopback_mode(loop_reg),
        .sum_valid(sum_valid), .sum_ready(sum_ready), .sum_data(sum_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
